>>> sv/macp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macp_pkg
// Types, constants and the character decoder shared by the address text
// parser.
// ----------------------------------------------------------------------------
package macp_pkg;

    localparam int unsigned ADDR_W    = 48;
    localparam int unsigned OCTET_W   = 8;
    localparam logic [2:0]  OCTETS    = 3'd6;
    localparam logic [4:0]  TEXT_LEN  = 5'd17;
    localparam logic [4:0]  COUNT_SAT = 5'd18;
    localparam logic [7:0]  CH_COLON  = 8'h3a;
    localparam logic [7:0]  CH_DASH   = 8'h2d;

    typedef enum logic [2:0] {
        PH_HIGH  = 3'd0,
        PH_LOW   = 3'd1,
        PH_AFTER = 3'd2,
        PH_BAD   = 3'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] character;
        logic       final_char;
    } t_in_beat;

    typedef struct packed {
        logic              valid_res;
        logic [ADDR_W-1:0] mac_address;
    } t_out_beat;

    typedef struct packed {
        t_phase            parse_phase;
        logic [2:0]        octet_count;
        logic [4:0]        char_count;
        logic [3:0]        high_nibble;
        logic [ADDR_W-1:0] address_shift;
    } t_state;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nibble;
    } t_hex;

    localparam t_state STATE_RESET = '{
        parse_phase:   PH_HIGH,
        octet_count:   3'd0,
        char_count:    5'd0,
        high_nibble:   4'd0,
        address_shift: '0
    };

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        logic [7:0] d;
        h = '{is_hex: 1'b0, nibble: 4'd0};
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            h = '{is_hex: 1'b1, nibble: d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            h = '{is_hex: 1'b1, nibble: d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            h = '{is_hex: 1'b1, nibble: d[3:0]};
        end
        return h;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_COLON) || (c == CH_DASH);
    endfunction

endpackage

>>> sv/macp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macp_step
// Next-state and result logic for one character of address text.
// ----------------------------------------------------------------------------
module macp_step (
    input  macp_pkg::t_state    i_state,
    input  macp_pkg::t_in_beat  i_beat,
    output macp_pkg::t_state    o_state,
    output macp_pkg::t_out_beat o_result
);

    macp_pkg::t_hex   hx;
    macp_pkg::t_state s;
    logic             sep;
    logic             ok;

    always_comb begin
        hx  = macp_pkg::hex_decode(i_beat.character);
        sep = macp_pkg::is_sep(i_beat.character);
        s   = i_state;
        ok  = 1'b0;

        if (s.char_count < macp_pkg::COUNT_SAT) begin
            s.char_count = s.char_count + 5'd1;
        end

        case (i_state.parse_phase)
            macp_pkg::PH_HIGH, macp_pkg::PH_AFTER: begin
                if (i_state.parse_phase == macp_pkg::PH_AFTER && sep) begin
                    s.parse_phase = macp_pkg::PH_HIGH;
                end else if (s.octet_count >= macp_pkg::OCTETS || !hx.is_hex) begin
                    s.parse_phase = macp_pkg::PH_BAD;
                end else begin
                    s.high_nibble = hx.nibble;
                    s.parse_phase = macp_pkg::PH_LOW;
                end
            end
            macp_pkg::PH_LOW: begin
                if (hx.is_hex || sep) begin
                    s.address_shift = {s.address_shift[macp_pkg::ADDR_W-macp_pkg::OCTET_W-1:0],
                                       (hx.is_hex ? s.high_nibble : 4'd0),
                                       (hx.is_hex ? hx.nibble : s.high_nibble)};
                    if (s.octet_count < macp_pkg::OCTETS) begin
                        s.octet_count = s.octet_count + 3'd1;
                    end
                    s.parse_phase = macp_pkg::PH_AFTER;
                end else begin
                    s.parse_phase = macp_pkg::PH_BAD;
                end
            end
            default: begin
                s.parse_phase = macp_pkg::PH_BAD;
            end
        endcase

        // one-digit octet ending the string
        if (i_beat.final_char && s.parse_phase == macp_pkg::PH_LOW) begin
            s.address_shift = {s.address_shift[macp_pkg::ADDR_W-macp_pkg::OCTET_W-1:0],
                               4'd0, s.high_nibble};
            if (s.octet_count < macp_pkg::OCTETS) begin
                s.octet_count = s.octet_count + 3'd1;
            end
            s.parse_phase = macp_pkg::PH_AFTER;
        end

        ok = (s.parse_phase != macp_pkg::PH_BAD) && (s.octet_count == macp_pkg::OCTETS)
             && (s.char_count == macp_pkg::TEXT_LEN);

        o_result.valid_res   = ok;
        o_result.mac_address = ok ? s.address_shift : '0;

        if (i_beat.final_char) begin
            o_state = macp_pkg::STATE_RESET;
        end else begin
            o_state = s;
        end
    end

endmodule

>>> sv/mac_address_text_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_address_text_parser_top
// Parses a 48-bit Ethernet address from text, one character per beat.
// ----------------------------------------------------------------------------
// One character beat is taken every cycle unless the input is stalled. Each
// beat is registered, then decoded against the parse state; the beat carrying
// the final-character flag yields one result beat, written from the input
// register into the output register. Input stalls only when a final character
// is ready to leave the input register while the output register still holds
// an untaken result; ordinary characters pass even while the output is stalled.
// The result flags a well-formed 17-character address and gives its octets,
// first octet in the top byte, or zero when the text is malformed.
module mac_address_text_parser_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  macp_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output macp_pkg::t_out_beat  o_out_beat
);

    logic                r_in_vld, n_in_vld;
    macp_pkg::t_in_beat  r_in;
    macp_pkg::t_state    r_state, n_state;
    logic                r_out_vld, n_out_vld;
    macp_pkg::t_out_beat r_out;
    macp_pkg::t_out_beat step_res;
    logic                advance;
    logic                in_take;

    macp_step u_step (
        .i_state  (r_state),
        .i_beat   (r_in),
        .o_state  (n_state),
        .o_result (step_res)
    );

    assign advance    = r_in_vld && !(r_in.final_char && r_out_vld && i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_vld = r_in_vld;
        if (in_take) begin
            n_in_vld = 1'b1;
        end else if (advance) begin
            n_in_vld = 1'b0;
        end

        n_out_vld = r_out_vld;
        if (advance && r_in.final_char) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= macp_pkg::STATE_RESET;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_beat;
        end
        if (advance && r_in.final_char) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

    a_octets_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.octet_count <= macp_pkg::OCTETS)
        else $error("octet count beyond six");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.char_count <= macp_pkg::COUNT_SAT)
        else $error("character count beyond saturation");

    a_zero_when_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.valid_res) |-> (r_out.mac_address == '0))
        else $error("address not zero on malformed text");

    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_in.final_char && r_out_vld))
        else $error("input stalled without a blocked final beat");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.final_char) |=> (r_state.char_count == 5'd0))
        else $error("state not cleared after final character");

endmodule

>>> dv/mac_address_text_parser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_address_text_parser_top_test
// Self-checking bench for the Ethernet address text parser. Strings are sent
// one character beat at a time. A short table of directed strings comes
// first, then random address texts, some clean and some corrupted, mixed
// with noise. Every result beat is checked against a behavioral parser kept
// in the bench, or against a fixed value for pinned directed strings. The
// sender idles in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module mac_address_text_parser_top_test;

    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned CHAR_TARGET  = 950;
    localparam int unsigned DIRECTED_CNT = 18;

    typedef struct {
        bit                  pinned;
        macp_pkg::t_out_beat val;
    } t_known;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    macp_pkg::t_in_beat  i_in_beat   = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    macp_pkg::t_out_beat o_out_beat;

    mac_address_text_parser_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    always #10 i_clk = ~i_clk;

    // bench copy of the parse state
    macp_pkg::t_phase            txt_phase   = macp_pkg::PH_HIGH;
    logic [2:0]                  txt_octets  = '0;
    logic [4:0]                  txt_chars   = '0;
    logic [3:0]                  txt_hi      = '0;
    logic [macp_pkg::ADDR_W-1:0] txt_addr    = '0;

    macp_pkg::t_out_beat parsed_addr_q[$];
    t_known              known_result_q[$];
    logic [7:0]          text_buf[$];

    int unsigned n_errors    = 0;
    int unsigned n_chars     = 0;
    int unsigned n_strings   = 0;
    int unsigned n_results   = 0;
    int unsigned n_good      = 0;
    int unsigned burst_left  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_run   = 0;
    int unsigned rx_cyc      = 0;

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b1, c[3:0]};
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            return {1'b1, c[3:0] + 4'd9};
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return 8'h30 + n;
        return (upper ? 8'h37 : 8'h57) + n;
    endfunction

    function automatic logic [7:0] any_sep();
        return ($urandom_range(0, 1) != 0) ? macp_pkg::CH_COLON : macp_pkg::CH_DASH;
    endfunction

    function automatic logic [7:0] some_char();
        case ($urandom_range(0, 3))
            0, 1: return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            2: return any_sep();
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic push_octet(input logic [7:0] v);
        txt_addr = {txt_addr[macp_pkg::ADDR_W-macp_pkg::OCTET_W-1:0], v};
        if (txt_octets < macp_pkg::OCTETS)
            txt_octets = txt_octets + 3'd1;
        txt_phase = macp_pkg::PH_AFTER;
    endtask

    task automatic parse_char(input macp_pkg::t_in_beat b, output macp_pkg::t_out_beat r);
        logic [4:0] d;
        logic       sep;
        logic       ok;
        d   = digit_of(b.character);
        sep = (b.character == macp_pkg::CH_COLON) || (b.character == macp_pkg::CH_DASH);
        r   = '0;
        if (txt_chars < macp_pkg::COUNT_SAT)
            txt_chars = txt_chars + 5'd1;
        if (txt_phase == macp_pkg::PH_AFTER && sep) begin
            txt_phase = macp_pkg::PH_HIGH;
        end else if (txt_phase == macp_pkg::PH_HIGH || txt_phase == macp_pkg::PH_AFTER) begin
            if (txt_octets >= macp_pkg::OCTETS || !d[4]) begin
                txt_phase = macp_pkg::PH_BAD;
            end else begin
                txt_hi    = d[3:0];
                txt_phase = macp_pkg::PH_LOW;
            end
        end else if (txt_phase == macp_pkg::PH_LOW) begin
            if (d[4])
                push_octet({txt_hi, d[3:0]});
            else if (sep)
                push_octet({4'd0, txt_hi});
            else
                txt_phase = macp_pkg::PH_BAD;
        end else begin
            txt_phase = macp_pkg::PH_BAD;
        end
        if (b.final_char) begin
            if (txt_phase == macp_pkg::PH_LOW)
                push_octet({4'd0, txt_hi});
            ok = (txt_phase != macp_pkg::PH_BAD) && (txt_octets == macp_pkg::OCTETS)
                 && (txt_chars == macp_pkg::TEXT_LEN);
            r.valid_res   = ok;
            r.mac_address = ok ? txt_addr : '0;
            txt_phase  = macp_pkg::PH_HIGH;
            txt_octets = '0;
            txt_chars  = '0;
            txt_hi     = '0;
            txt_addr   = '0;
        end
    endtask

    // monitor: prediction on input beats, checking on output beats
    always @(posedge i_clk) begin
        macp_pkg::t_out_beat r;
        t_known              k;
        macp_pkg::t_out_beat e;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                parse_char(i_in_beat, r);
                if (i_in_beat.final_char) begin
                    k = known_result_q.pop_front();
                    parsed_addr_q.push_back(k.pinned ? k.val : r);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                n_results = n_results + 1;
                if (o_out_beat.valid_res === 1'b1)
                    n_good = n_good + 1;
                if (parsed_addr_q.size() == 0) begin
                    $display("%0t: result beat with none expected: valid_res %0b mac_address %h",
                             $time, o_out_beat.valid_res, o_out_beat.mac_address);
                    n_errors = n_errors + 1;
                end else begin
                    e = parsed_addr_q.pop_front();
                    if (o_out_beat.valid_res !== e.valid_res) begin
                        $display("%0t: valid_res expected %0b actual %0b",
                                 $time, e.valid_res, o_out_beat.valid_res);
                        n_errors = n_errors + 1;
                    end
                    if (o_out_beat.mac_address !== e.mac_address) begin
                        $display("%0t: mac_address expected %h actual %h",
                                 $time, e.mac_address, o_out_beat.mac_address);
                        n_errors = n_errors + 1;
                    end
                end
            end
        end
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // receiver: quiet windows, sparse stalls and longer stall runs
    always @(posedge i_clk) begin
        rx_cyc = rx_cyc + 1;
        if (stall_run > 0) begin
            stall_run = stall_run - 1;
            i_out_stall <= 1'b1;
        end else if (rx_cyc[8:7] == 2'b00) begin
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_run = $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic put_char(input logic [7:0] ch, input logic fin);
        int unsigned idle;
        if (burst_left == 0) begin
            idle = $urandom_range(0, 6);
            if (idle > 0) begin
                i_in_valid <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 20);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= '{character: ch, final_char: fin};
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        burst_left = burst_left - 1;
        n_chars = n_chars + 1;
    endtask

    task automatic send_text(input bit pinned, input macp_pkg::t_out_beat val);
        t_known k;
        k.pinned = pinned;
        k.val    = val;
        known_result_q.push_back(k);
        n_strings = n_strings + 1;
        for (int i = 0; i < text_buf.size(); i++)
            put_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic directed_row(input int idx, output string s, output bit pinned,
                                output macp_pkg::t_out_beat val);
        pinned = 1'b1;
        val    = '0;
        case (idx)
            0: s = "00:00:00:00:00:00";
            1: begin
                s   = "FF-ff-FF-ff-FF-ff";
                val = '{valid_res: 1'b1, mac_address: 48'hffff_ffff_ffff};
            end
            2: begin
                s   = "0a:1B-2c:3D-4e:5F";
                val = '{valid_res: 1'b1, mac_address: 48'h0a1b_2c3d_4e5f};
            end
            3: begin s = "1::23:45:67:89:ab";  pinned = 1'b0; end
            4: begin s = "1:23:45:67:89:ab:";  pinned = 1'b0; end
            5: s = "12:34:56:78:9a:b";
            6: s = "a";
            7: s = "1:2:34:56:78:9abc";
            8: s = "12:34:56:78:9a";
            9: s = "12:34:56:78:9a:bc:de:f0:12:34:56";
            10: s = "12:34:56:78:9a:b\377";
            11: s = "/2:34:56:78:9a:bc";
            12: s = "12:3G:56:78:9a:bc";
            13: s = "12:34;56:78:9a:bc";
            14: s = "\0012:34:56:78:9a:@`g\200";
            15: s = "::";
            16: s = "a-b-c-d-e-f";
            default: begin s = "12:34:56:78:9a:bc"; pinned = 1'b0; end
        endcase
        // full-value rows 0..2 are well-formed; every other pinned row is malformed
        if (pinned && idx == 0)
            val.valid_res = 1'b1;
    endtask

    task automatic make_address_text();
        logic [7:0] v;
        bit         one_digit;
        bit         up;
        text_buf.delete();
        for (int i = 0; i < 6; i++) begin
            v = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15))
                                            : 8'($urandom_range(0, 255));
            up = 1'($urandom_range(0, 1));
            one_digit = (v < 8'd16) && ($urandom_range(0, 1) != 0);
            if (one_digit) begin
                text_buf.push_back(hex_char(v[3:0], up));
                text_buf.push_back(any_sep());
                if (i < 5)
                    text_buf.push_back(any_sep());
            end else begin
                text_buf.push_back(hex_char(v[7:4], up));
                text_buf.push_back(hex_char(v[3:0], 1'($urandom_range(0, 1))));
                if (i < 5)
                    text_buf.push_back(any_sep());
            end
        end
        case ($urandom_range(0, 9))
            6: text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(1, 255));
            7: text_buf.delete($urandom_range(0, text_buf.size() - 1));
            8: text_buf.insert($urandom_range(0, text_buf.size()), some_char());
            9: repeat ($urandom_range(1, 25)) text_buf.push_back(some_char());
            default: ;
        endcase
    endtask

    initial begin
        string               s;
        bit                  pinned;
        macp_pkg::t_out_beat val;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_CNT; r++) begin
            directed_row(r, s, pinned, val);
            text_buf.delete();
            for (int i = 0; i < s.len(); i++)
                text_buf.push_back(s[i]);
            send_text(pinned, val);
        end

        while (n_chars < CHAR_TARGET) begin
            if ($urandom_range(0, 7) == 0) begin
                text_buf.delete();
                repeat ($urandom_range(1, 20)) text_buf.push_back(some_char());
            end else begin
                make_address_text();
            end
            send_text(1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (parsed_addr_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d characters in %0d strings; %0d result beats checked, %0d well-formed.",
                 n_chars, n_strings, n_results, n_good);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
